// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define SAHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be true outside reset
`define SAHS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SAHS_ASSERT(lbl, clk, rstn, prop, msg)
`define SAHS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== sv/sahs_pkg.sv =====
// types and constants of the homing sequencer
`default_nettype none

package sahs_pkg;

  // configuration register data and index widths
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;

  // default counter width
  localparam int unsigned CountWidthDef = 16;

  // register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_RELEASE_MODE    = 3'd0,
    REG_BACKOFF_STEPS   = 3'd1,
    REG_OVERSHOOT_STEPS = 3'd2,
    REG_FINAL_STEPS     = 3'd3,
    REG_TOWARD_LEVEL    = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic                    ReleaseModeRst    = 1'b1;
  localparam logic [CfgDataWidth-1:0] BackoffStepsRst   = 16'd41;
  localparam logic [CfgDataWidth-1:0] OvershootStepsRst = 16'd41;
  localparam logic [CfgDataWidth-1:0] FinalStepsRst     = 16'd0;
  localparam logic                    TowardLevelRst    = 1'b0;

  // request kinds
  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  // sequence phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RELEASE   = 3'd1,
    PH_BACKOFF   = 3'd2,
    PH_SEEK      = 3'd3,
    PH_OVERSHOOT = 3'd4,
    PH_FINAL     = 3'd5
  } phase_e;

endpackage

`default_nettype wire

// ===== sv/sahs_req_if.sv =====
// request channel: step tick or start with switch sample
`default_nettype none

interface sahs_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic switch_active;

  modport source (output valid, output kind, output switch_active, input ready);
  modport sink   (input valid, input kind, input switch_active, output ready);
endinterface

`default_nettype wire

// ===== sv/sahs_res_if.sv =====
// result channel: step, direction and sequence status
`default_nettype none

interface sahs_res_if;
  logic valid;
  logic ready;
  logic step_pulse;
  logic direction;
  logic busy_res;
  logic done_res;

  modport source (output valid, output step_pulse, output direction, output busy_res,
                  output done_res, input ready);
  modport sink   (input valid, input step_pulse, input direction, input busy_res,
                  input done_res, output ready);
endinterface

`default_nettype wire

// ===== sv/sahs_cfg_if.sv =====
// configuration write channel
`default_nettype none

interface sahs_cfg_if;
  import sahs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  idx;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/stepper_axis_homing_sequencer_top.sv =====
// homing sequencer for one stepper axis against a limit switch
`default_nettype none
`include "assert_macros.svh"

// Homes one axis against a limit switch. A start request samples the switch and
// begins a sequence (if active, step away until it releases in release mode,
// then back off; seek toward the switch, overshoot, final steps away); each tick
// request then returns one result telling whether to step and in which
// direction, plus busy and done flags. Every request returns exactly one result.
// A request enters the input register and its result the result register. One
// request is taken per cycle while the result slot is free or drains; a single
// pass of phase checks between the registers falls through all phases whose
// condition or count is met. Configuration writes are taken at any time, one
// per cycle, and are meant to be issued only while no request is in flight.
module stepper_axis_homing_sequencer_top #(
  parameter int unsigned COUNT_WIDTH = sahs_pkg::CountWidthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sahs_cfg_if.sink    cfg_i,
  sahs_req_if.sink    req_i,
  sahs_res_if.source  res_o
);
  import sahs_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned LW = CW + CfgDataWidth;

  // configuration registers
  logic                    release_mode_q;
  logic [CfgDataWidth-1:0] backoff_steps_q;
  logic [CfgDataWidth-1:0] overshoot_steps_q;
  logic [CfgDataWidth-1:0] final_steps_q;
  logic                    toward_level_q;

  // input register
  logic in_vld_q;
  logic kind_q;
  logic sw_q;

  // sequence state
  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // result register
  logic out_vld_q;
  logic step_q, step_d;
  logic dir_q, dir_d;
  logic busy_q, busy_d;
  logic done_q, done_d;

  logic advance;

  // saturate a register count to the counter range
  function automatic logic [CW-1:0] load_count(input logic [CfgDataWidth-1:0] v);
    logic [LW-1:0] wide;
    logic [LW-1:0] lim;
    wide = {{CW{1'b0}}, v};
    lim  = {{CfgDataWidth{1'b0}}, {CW{1'b1}}};
    if (wide > lim) begin
      return {CW{1'b1}};
    end
    return wide[CW-1:0];
  endfunction

  // configuration writes, indexes beyond the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_mode_q    <= ReleaseModeRst;
      backoff_steps_q   <= BackoffStepsRst;
      overshoot_steps_q <= OvershootStepsRst;
      final_steps_q     <= FinalStepsRst;
      toward_level_q    <= TowardLevelRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        REG_RELEASE_MODE:    release_mode_q    <= cfg_i.data[0];
        REG_BACKOFF_STEPS:   backoff_steps_q   <= cfg_i.data;
        REG_OVERSHOOT_STEPS: overshoot_steps_q <= cfg_i.data;
        REG_FINAL_STEPS:     final_steps_q     <= cfg_i.data;
        REG_TOWARD_LEVEL:    toward_level_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // handshake: input register moves on when the result slot is free or drains
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q <= req_i.kind;
      sw_q   <= req_i.switch_active;
    end
  end

  // phase decision with fall-through of finished phases
  always_comb begin
    logic settled;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    step_d  = 1'b0;
    dir_d   = toward_level_q;
    done_d  = 1'b0;
    settled = 1'b0;

    if (kind_q == KIND_START) begin
      settled = 1'b1;
      if (sw_q) begin
        if (release_mode_q) begin
          phase_d = PH_RELEASE;
          cnt_d   = '0;
        end else begin
          phase_d = PH_BACKOFF;
          cnt_d   = load_count(backoff_steps_q);
        end
      end else begin
        phase_d = PH_SEEK;
        cnt_d   = '0;
      end
    end else begin
      if (phase_d == PH_IDLE) begin
        settled = 1'b1;
      end
      // step away while the switch stays active
      if (!settled && phase_d == PH_RELEASE) begin
        if (sw_q) begin
          step_d  = 1'b1;
          dir_d   = ~toward_level_q;
          settled = 1'b1;
        end else begin
          phase_d = PH_BACKOFF;
          cnt_d   = load_count(backoff_steps_q);
        end
      end
      // counted steps away
      if (!settled && phase_d == PH_BACKOFF) begin
        if (cnt_d != '0) begin
          cnt_d   = cnt_d - 1'b1;
          step_d  = 1'b1;
          dir_d   = ~toward_level_q;
          settled = 1'b1;
        end else begin
          phase_d = PH_SEEK;
        end
      end
      // seek toward the switch
      if (!settled && phase_d == PH_SEEK) begin
        if (!sw_q) begin
          step_d  = 1'b1;
          dir_d   = toward_level_q;
          settled = 1'b1;
        end else begin
          phase_d = PH_OVERSHOOT;
          cnt_d   = load_count(overshoot_steps_q);
        end
      end
      // overshoot toward the switch
      if (!settled && phase_d == PH_OVERSHOOT) begin
        if (cnt_d != '0) begin
          cnt_d   = cnt_d - 1'b1;
          step_d  = 1'b1;
          dir_d   = toward_level_q;
          settled = 1'b1;
        end else begin
          phase_d = PH_FINAL;
          cnt_d   = load_count(final_steps_q);
        end
      end
      // final steps away, then done
      if (!settled && phase_d == PH_FINAL) begin
        if (cnt_d != '0) begin
          cnt_d   = cnt_d - 1'b1;
          step_d  = 1'b1;
          dir_d   = ~toward_level_q;
        end else begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
          done_d  = 1'b1;
        end
        settled = 1'b1;
      end
      // unknown phase code returns to idle
      if (!settled) begin
        phase_d = PH_IDLE;
      end
    end

    busy_d = (phase_d != PH_IDLE);
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      step_q <= step_d;
      dir_q  <= dir_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.step_pulse = step_q;
  assign res_o.direction  = dir_q;
  assign res_o.busy_res   = busy_q;
  assign res_o.done_res   = done_q;

  // checks
  `SAHS_ASSERT_NEVER(a_done_no_step, clk_i, rst_ni,
      out_vld_q && done_q && (step_q || busy_q), "done result steps or stays busy")
  `SAHS_ASSERT(a_idle_tick_quiet, clk_i, rst_ni,
      (advance && kind_q == KIND_TICK && phase_q == PH_IDLE) |=> (!step_q && !busy_q),
      "tick while idle produced a step")
  `SAHS_ASSERT(a_uncounted_phase_zero, clk_i, rst_ni,
      (phase_q == PH_SEEK || phase_q == PH_RELEASE) |-> (cnt_q == '0),
      "counter not zero in an uncounted phase")
  `SAHS_ASSERT(a_busy_matches_phase, clk_i, rst_ni,
      advance |=> (busy_q == (phase_q != PH_IDLE)),
      "busy flag disagrees with sequence phase")

endmodule

`default_nettype wire
